// ===== sv/averaged_boost_duty_regulator_top_defines.svh =====
// Assertion macros shared by the regulator's checker.
`ifndef AVERAGED_BOOST_DUTY_REGULATOR_TOP_DEFINES_SVH
`define AVERAGED_BOOST_DUTY_REGULATOR_TOP_DEFINES_SVH

// Concurrent assertion on the rising clock edge, switched off while reset is high.
`define ABDR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Concurrent assertion on the rising clock edge that also holds through reset.
`define ABDR_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== sv/abdr_pkg.sv =====
// Types and constants shared by the averaged boost duty regulator.
package abdr_pkg;

   // Field widths of the stream words.
   localparam int unsigned SAMPLE_W    = 10;
   localparam int unsigned SAMPLE_MAX  = 1023;
   localparam int unsigned DUTY_W      = 8;
   localparam int unsigned REQ_TDATA_W = 16;
   localparam int unsigned RSP_TDATA_W = 56;
   localparam int unsigned RSP_PAD_W   = 6;

   // Configuration port widths and register indexes.
   localparam int unsigned CSR_INDEX_W = 8;
   localparam int unsigned CSR_DATA_W  = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_FLOOR   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DUTY_CEILING = 8'd1;

   // Reset values of the duty limits.
   localparam logic [DUTY_W-1:0] DUTY_FLOOR_RESET   = 8'd0;
   localparam logic [DUTY_W-1:0] DUTY_CEILING_RESET = 8'd255;

   // Round-robin converter channels.
   typedef enum logic [1:0] {
      CH_VOUT     = 2'd0,
      CH_SETPOINT = 2'd1,
      CH_SUPPLY   = 2'd2,
      CH_CURRENT  = 2'd3
   } channel_type;

   // Duty limits handed from the register block to the duty stepper.
   typedef struct packed {
      logic [DUTY_W-1:0] duty_floor;
      logic [DUTY_W-1:0] duty_ceiling;
   } duty_limits_type;

   // Result word, last field in the lowest bits.
   typedef struct packed {
      logic [RSP_PAD_W-1:0] pad;
      channel_type          channel_served;
      logic [SAMPLE_W-1:0]  supply_level;
      logic [SAMPLE_W-1:0]  target_level;
      logic [SAMPLE_W-1:0]  current_average;
      logic [SAMPLE_W-1:0]  voltage_average;
      logic [DUTY_W-1:0]    duty_out;
   } rsp_word_type;

endpackage

// ===== sv/averaged_boost_duty_regulator_top.sv =====
// Averaged boost duty regulator: top level with channel routing and result register.
//
// Each request word carries one 10-bit converter result in req_tdata[9:0].
// Words are routed round-robin to output voltage, setpoint, input voltage and
// current. Voltage and current samples are averaged over blocks of
// VOLTAGE_SAMPLES and CURRENT_SAMPLES, and after every word the duty steps by
// one toward the setpoint, held between the floor and ceiling registers.
// Every request word yields exactly one response word on rsp_, carrying the
// duty, both averages, the latest setpoint and supply samples and the channel.
// An accepted word is shown on rsp_ in the next cycle. Throughput is one word
// per cycle while rsp_tready stays high; the accumulate, reciprocal multiply
// and duty compare all sit in the single stage ahead of the result register.
// When the receiver stalls, the waiting response word holds and req_tready
// falls until it is taken; req_tready is high whenever the result register is
// empty or being emptied. The csr_ port writes the floor (index 0) and the
// ceiling (index 1) and is always ready; other indexes are ignored. Reset
// returns the channel to output voltage, clears all sums, averages and the
// duty, and sets the limits to 0 and 255.
module averaged_boost_duty_regulator_top #(
   parameter int unsigned VOLTAGE_SAMPLES = 16,
   parameter int unsigned CURRENT_SAMPLES = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata: sample [9:0], zero pad [15:10].
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [abdr_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // rsp_tdata: duty_out [7:0], voltage_average [17:8], current_average [27:18],
   // target_level [37:28], supply_level [47:38], channel_served [49:48], pad [55:50].
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [abdr_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [abdr_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [abdr_pkg::CSR_DATA_W-1:0]     csr_data
);

   logic                          accept_c;
   logic [abdr_pkg::SAMPLE_W-1:0] sample_c;
   abdr_pkg::channel_type         channel_ff, channel_in;
   logic [abdr_pkg::SAMPLE_W-1:0] setpoint_ff, setpoint_in;
   logic [abdr_pkg::SAMPLE_W-1:0] supply_ff, supply_in;
   abdr_pkg::duty_limits_type     limits_ff, limits_in;
   logic [abdr_pkg::SAMPLE_W-1:0] vout_mean_c;
   logic [abdr_pkg::SAMPLE_W-1:0] current_avg_c;
   logic [abdr_pkg::DUTY_W-1:0]   duty_c;
   logic                          rsp_valid_ff, rsp_valid_in;
   abdr_pkg::rsp_word_type        rsp_word_ff, rsp_word_in;

   // Handshakes: a new word enters whenever the result register can take it.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept_c   = req_tvalid && req_tready;
   assign sample_c   = req_tdata[abdr_pkg::SAMPLE_W-1:0];
   assign csr_ready  = 1'b1;

   // Limit registers.
   always_comb begin
      limits_in = limits_ff;
      if (csr_valid) begin
         case (csr_index)
            abdr_pkg::CSR_DUTY_FLOOR:   limits_in.duty_floor   = csr_data;
            abdr_pkg::CSR_DUTY_CEILING: limits_in.duty_ceiling = csr_data;
            default:                    limits_in = limits_ff;
         endcase
      end
   end

   // Channel rotation and the held setpoint and supply samples.
   always_comb begin
      channel_in  = channel_ff;
      setpoint_in = setpoint_ff;
      supply_in   = supply_ff;
      if (accept_c) begin
         channel_in = abdr_pkg::channel_type'(2'(channel_ff + 2'd1));
         if (channel_ff == abdr_pkg::CH_SETPOINT) begin
            setpoint_in = sample_c;
         end
         if (channel_ff == abdr_pkg::CH_SUPPLY) begin
            supply_in = sample_c;
         end
      end
   end

   abdr_averager #(
      .SAMPLES (VOLTAGE_SAMPLES)
   ) u_vout_mean (
      .clock     (clock),
      .reset     (reset),
      .sample_en (accept_c && (channel_ff == abdr_pkg::CH_VOUT)),
      .sample    (sample_c),
      .avg_next  (vout_mean_c)
   );

   abdr_averager #(
      .SAMPLES (CURRENT_SAMPLES)
   ) u_current_avg (
      .clock     (clock),
      .reset     (reset),
      .sample_en (accept_c && (channel_ff == abdr_pkg::CH_CURRENT)),
      .sample    (sample_c),
      .avg_next  (current_avg_c)
   );

   abdr_duty_step u_duty_step (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept_c),
      .vout_mean   (vout_mean_c),
      .setpoint    (setpoint_in),
      .limits      (limits_ff),
      .duty_next   (duty_c)
   );

   // Result register: loads on every accepted word, empties when taken.
   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (accept_c) begin
         rsp_valid_in                = 1'b1;
         rsp_word_in.pad             = '0;
         rsp_word_in.channel_served  = channel_ff;
         rsp_word_in.supply_level    = supply_in;
         rsp_word_in.target_level    = setpoint_in;
         rsp_word_in.current_average = current_avg_c;
         rsp_word_in.voltage_average = vout_mean_c;
         rsp_word_in.duty_out        = duty_c;
      end
   end

   // Control and held state.
   always_ff @(posedge clock) begin
      if (reset) begin
         channel_ff             <= abdr_pkg::CH_VOUT;
         setpoint_ff            <= '0;
         supply_ff              <= '0;
         limits_ff.duty_floor   <= abdr_pkg::DUTY_FLOOR_RESET;
         limits_ff.duty_ceiling <= abdr_pkg::DUTY_CEILING_RESET;
         rsp_valid_ff           <= 1'b0;
      end else begin
         channel_ff   <= channel_in;
         setpoint_ff  <= setpoint_in;
         supply_ff    <= supply_in;
         limits_ff    <= limits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result payload needs no reset.
   always_ff @(posedge clock) begin
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff;

endmodule

// ===== sv/abdr_averager.sv =====
// Block averager: sums samples and publishes sum divided by the block length.
module abdr_averager #(
   parameter int unsigned SAMPLES = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          sample_en,
   input  logic [abdr_pkg::SAMPLE_W-1:0] sample,
   output logic [abdr_pkg::SAMPLE_W-1:0] avg_next
);

   localparam int unsigned ACC_W   = $clog2(SAMPLES * abdr_pkg::SAMPLE_MAX + 1);
   localparam int unsigned CNT_W   = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
   localparam int unsigned SHIFT   = ACC_W + $clog2(SAMPLES);
   localparam int unsigned RECIP_W = SHIFT + 1;
   localparam int unsigned PROD_W  = ACC_W + RECIP_W;
   // Rounded-up reciprocal; exact floor division for every sum below 2**ACC_W.
   localparam longint unsigned RECIP = ((64'd1 << SHIFT) + SAMPLES - 1) / SAMPLES;

   logic [ACC_W-1:0]              acc_ff, acc_in;
   logic [CNT_W-1:0]              cnt_ff, cnt_in;
   logic [abdr_pkg::SAMPLE_W-1:0] avg_ff, avg_in;
   logic [ACC_W-1:0]              sum_c;
   logic [PROD_W-1:0]             product_c;
   logic [abdr_pkg::SAMPLE_W-1:0] quotient_c;
   logic                          last_c;

   // Running sum including this sample, and its quotient by the block length.
   assign sum_c      = acc_ff + ACC_W'(sample);
   assign product_c  = PROD_W'(sum_c) * PROD_W'(RECIP_W'(RECIP));
   assign quotient_c = product_c[SHIFT +: abdr_pkg::SAMPLE_W];
   assign last_c     = (cnt_ff == CNT_W'(SAMPLES - 1));

   // The block closes on its last sample: publish and start afresh.
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      avg_in = avg_ff;
      if (sample_en) begin
         if (last_c) begin
            acc_in = '0;
            cnt_in = '0;
            avg_in = quotient_c;
         end else begin
            acc_in = sum_c;
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
         cnt_ff <= '0;
         avg_ff <= '0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         avg_ff <= avg_in;
      end
   end

   assign avg_next = avg_in;

endmodule

// ===== sv/abdr_duty_step.sv =====
// Duty stepper: moves the duty by one toward the setpoint within the limits.
module abdr_duty_step (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step_en,
   input  logic [abdr_pkg::SAMPLE_W-1:0] vout_mean,
   input  logic [abdr_pkg::SAMPLE_W-1:0] setpoint,
   input  abdr_pkg::duty_limits_type     limits,
   output logic [abdr_pkg::DUTY_W-1:0]   duty_next
);

   logic [abdr_pkg::DUTY_W-1:0] duty_ff, duty_in;

   // Step up when the output sags, down when it overshoots, hold when equal.
   always_comb begin
      duty_in = duty_ff;
      if (step_en) begin
         if (vout_mean < setpoint) begin
            if (duty_ff >= limits.duty_ceiling) begin
               duty_in = limits.duty_ceiling;
            end else begin
               duty_in = duty_ff + abdr_pkg::DUTY_W'(1);
            end
         end else if (vout_mean > setpoint) begin
            if (duty_ff <= limits.duty_floor) begin
               duty_in = limits.duty_floor;
            end else begin
               duty_in = duty_ff - abdr_pkg::DUTY_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_ff <= '0;
      end else begin
         duty_ff <= duty_in;
      end
   end

   assign duty_next = duty_in;

endmodule

// ===== sv/abdr_checker.sv =====
// Port-level checker for the regulator, bound to its top level.
`include "averaged_boost_duty_regulator_top_defines.svh"

module abdr_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [abdr_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   // A response word that is not taken stays on the bus unchanged.
   `ABDR_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "response word changed while stalled")

   // Every accepted request word shows its response on the next cycle.
   `ABDR_ASSERT(a_one_cycle, req_tvalid && req_tready |=> rsp_tvalid, "no response word after an accepted request")

   // A waiting response word is never overwritten by a new request.
   `ABDR_ASSERT(a_no_overrun, rsp_tvalid && !rsp_tready |-> !req_tready, "request taken while a response word waits")

   // Reset empties the result register.
   `ABDR_ASSERT_ALWAYS(a_reset_empty, $past(reset) && !reset |-> !rsp_tvalid, "response word valid straight after reset")

endmodule

bind averaged_boost_duty_regulator_top abdr_checker u_abdr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== verif/tb.sv =====
// Self-checking bench for the averaged boost duty regulator: stream driver, monitor, predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned VOLT_BLOCK      = 16;
   localparam int unsigned CUR_BLOCK       = 16;
   localparam int unsigned WORDS_PER_PHASE = 180;
   localparam int unsigned PHASE_COUNT     = 8;

   // Register indexes past the end of the map, which the block must ignore.
   localparam logic [abdr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_LOW = 8'd2;
   localparam logic [abdr_pkg::CSR_INDEX_W-1:0] CSR_UNUSED_TOP = 8'hFF;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [abdr_pkg::REQ_TDATA_W-1:0] req_tdata  = '0;   // sample [9:0], zero pad [15:10]
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [abdr_pkg::RSP_TDATA_W-1:0] rsp_tdata;   // duty, voltage avg, current avg, target,
                                                  // supply, channel, pad (lowest bit up)
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [abdr_pkg::CSR_INDEX_W-1:0] csr_index  = '0;
   logic [abdr_pkg::CSR_DATA_W-1:0]  csr_data   = '0;

   averaged_boost_duty_regulator_top #(
      .VOLTAGE_SAMPLES (VOLT_BLOCK),
      .CURRENT_SAMPLES (CUR_BLOCK)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Free-running clock, 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Samples waiting to be sent and response words predicted but not yet seen.
   logic [abdr_pkg::SAMPLE_W-1:0] sample_queue [$];
   abdr_pkg::rsp_word_type        predicted_words [$];
   int unsigned                   queued_count   = 0;
   int unsigned                   send_idle_pct  = 0;
   int unsigned                   stall_pct      = 0;
   int unsigned                   mismatch_count = 0;

   // Predictor copy of the limits and the regulator state.
   logic [abdr_pkg::DUTY_W-1:0]   floor_reg     = abdr_pkg::DUTY_FLOOR_RESET;
   logic [abdr_pkg::DUTY_W-1:0]   ceiling_reg   = abdr_pkg::DUTY_CEILING_RESET;
   abdr_pkg::channel_type         next_channel  = abdr_pkg::CH_VOUT;
   logic [13:0]                   vout_sum      = '0;
   logic [13:0]                   current_sum   = '0;
   logic [8:0]                    vout_taken    = '0;
   logic [8:0]                    current_taken = '0;
   logic [abdr_pkg::SAMPLE_W-1:0] vout_avg      = '0;
   logic [abdr_pkg::SAMPLE_W-1:0] current_avg   = '0;
   logic [abdr_pkg::SAMPLE_W-1:0] setpoint_held = '0;
   logic [abdr_pkg::SAMPLE_W-1:0] supply_held   = '0;
   logic [abdr_pkg::DUTY_W-1:0]   duty_now      = '0;

   // Route one sample, update the averages and step the duty toward the setpoint.
   function automatic abdr_pkg::rsp_word_type regulate_sample(
      input logic [abdr_pkg::SAMPLE_W-1:0] sample);
      abdr_pkg::rsp_word_type word;
      word = '0;
      case (next_channel)
         abdr_pkg::CH_VOUT: begin
            vout_sum   = vout_sum + 14'(sample);
            vout_taken = vout_taken + 9'd1;
            if (vout_taken >= VOLT_BLOCK) begin
               vout_avg   = abdr_pkg::SAMPLE_W'(vout_sum / VOLT_BLOCK);
               vout_sum   = '0;
               vout_taken = '0;
            end
         end
         abdr_pkg::CH_SETPOINT: setpoint_held = sample;
         abdr_pkg::CH_SUPPLY:   supply_held   = sample;
         default: begin
            current_sum   = current_sum + 14'(sample);
            current_taken = current_taken + 9'd1;
            if (current_taken >= CUR_BLOCK) begin
               current_avg   = abdr_pkg::SAMPLE_W'(current_sum / CUR_BLOCK);
               current_sum   = '0;
               current_taken = '0;
            end
         end
      endcase
      word.channel_served = next_channel;
      next_channel = abdr_pkg::channel_type'(2'(next_channel + 2'd1));

      // A limit that has been reached or passed pins the duty to that limit.
      if (vout_avg < setpoint_held) begin
         duty_now = (duty_now >= ceiling_reg) ? ceiling_reg : duty_now + 8'd1;
      end else if (vout_avg > setpoint_held) begin
         duty_now = (duty_now <= floor_reg) ? floor_reg : duty_now - 8'd1;
      end

      word.duty_out        = duty_now;
      word.voltage_average = vout_avg;
      word.current_average = current_avg;
      word.target_level    = setpoint_held;
      word.supply_level    = supply_held;
      return word;
   endfunction

   task automatic flag_mismatch(input string what, input int unsigned got,
                                input int unsigned want);
      if (mismatch_count < 100) begin
         $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   // Compare one accepted response word with the oldest prediction.
   task automatic check_word(input abdr_pkg::rsp_word_type got);
      abdr_pkg::rsp_word_type want;
      if (predicted_words.size() == 0) begin
         flag_mismatch("unexpected response word", got.duty_out, 0);
      end else begin
         want = predicted_words.pop_front();
         if (got.duty_out != want.duty_out)
            flag_mismatch("duty_out", got.duty_out, want.duty_out);
         if (got.voltage_average != want.voltage_average)
            flag_mismatch("voltage_average", got.voltage_average, want.voltage_average);
         if (got.current_average != want.current_average)
            flag_mismatch("current_average", got.current_average, want.current_average);
         if (got.target_level != want.target_level)
            flag_mismatch("target_level", got.target_level, want.target_level);
         if (got.supply_level != want.supply_level)
            flag_mismatch("supply_level", got.supply_level, want.supply_level);
         if (got.channel_served != want.channel_served)
            flag_mismatch("channel_served", got.channel_served, want.channel_served);
      end
   endtask

   // Request driver: predicts each accepted word and offers the next one.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            predicted_words.push_back(regulate_sample(req_tdata[abdr_pkg::SAMPLE_W-1:0]));
         end
         if (sample_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tdata  <= abdr_pkg::REQ_TDATA_W'(sample_queue.pop_front());
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_word(abdr_pkg::rsp_word_type'(rsp_tdata));
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic queue_sample(input logic [abdr_pkg::SAMPLE_W-1:0] sample);
      sample_queue.push_back(sample);
      queued_count++;
   endtask

   // Uniform sample with extra weight on the two ends of the range.
   function automatic logic [abdr_pkg::SAMPLE_W-1:0] any_sample();
      case ($urandom_range(9))
         0:       return '0;
         1:       return abdr_pkg::SAMPLE_W'(abdr_pkg::SAMPLE_MAX);
         default: return abdr_pkg::SAMPLE_W'($urandom_range(abdr_pkg::SAMPLE_MAX));
      endcase
   endfunction

   // A stretch of rounds around one voltage level, so that the average settles
   // and the setpoint can be placed on, just beside or far from it.
   task automatic queue_rounds(input int unsigned rounds);
      int unsigned level;
      int unsigned noise_pct;
      int unsigned target_mode;
      int unsigned offset;
      int unsigned setpoint;
      level       = any_sample();
      noise_pct   = ($urandom_range(2) == 0) ? 0 : $urandom_range(40);
      target_mode = $urandom_range(4);
      offset      = (target_mode == 4) ? $urandom_range(1, 40) : 1;
      for (int unsigned n = 0; n < rounds * 4; n++) begin
         case (abdr_pkg::channel_type'(queued_count % 4))
            abdr_pkg::CH_VOUT: begin
               queue_sample(($urandom_range(99) < noise_pct) ? any_sample() :
                            abdr_pkg::SAMPLE_W'(level));
            end
            abdr_pkg::CH_SETPOINT: begin
               case (target_mode)
                  0, 1:    setpoint = level;
                  2:       setpoint = (level + offset > abdr_pkg::SAMPLE_MAX) ?
                                      abdr_pkg::SAMPLE_MAX : level + offset;
                  3:       setpoint = (level < offset) ? 0 : level - offset;
                  default: setpoint = ($urandom_range(1)) ? any_sample() :
                                      ((level < offset) ? 0 : level - offset);
               endcase
               queue_sample(abdr_pkg::SAMPLE_W'(setpoint));
            end
            default: queue_sample(any_sample());
         endcase
      end
   endtask

   // Wait until every queued word has been sent and every response checked.
   task automatic wait_idle();
      while (sample_queue.size() != 0 || req_tvalid || predicted_words.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [abdr_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [abdr_pkg::CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         abdr_pkg::CSR_DUTY_FLOOR:   floor_reg   = value;
         abdr_pkg::CSR_DUTY_CEILING: ceiling_reg = value;
         default: ;
      endcase
      csr_valid <= 1'b0;
   endtask

   // Main sequence: directed words, then phases of limits and idling patterns.
   initial begin
      logic [abdr_pkg::DUTY_W-1:0]   floors [PHASE_COUNT];
      logic [abdr_pkg::DUTY_W-1:0]   ceilings [PHASE_COUNT];
      logic [abdr_pkg::SAMPLE_W-1:0] directed [24];
      int unsigned                   phase_end;
      int unsigned                   rounds;
      floors   = '{8'd0,   8'd40,  8'd200, 8'd0, 8'd255, 8'd255, 8'd0, 8'd0};
      ceilings = '{8'd255, 8'd200, 8'd40,  8'd0, 8'd255, 8'd0,   8'd0, 8'd255};
      floors[6]   = abdr_pkg::DUTY_W'($urandom_range(255));
      ceilings[6] = abdr_pkg::DUTY_W'($urandom_range(255));
      // Rounds of output voltage, setpoint, supply and current.
      directed = '{10'd1023, 10'd1023, 10'd1023, 10'd1023,
                   10'd0,    10'd1,    10'd0,    10'd0,
                   10'd1023, 10'd1023, 10'd1,    10'd1023,
                   10'd1,    10'd0,    10'd1023, 10'd1,
                   10'd1023, 10'd1023, 10'd512,  10'd1023,
                   10'd682,  10'd341,  10'd0,    10'd1023};

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Writes to indexes outside the map must leave the limits alone.
      write_register(CSR_UNUSED_LOW, 8'hAA);
      write_register(CSR_UNUSED_TOP, 8'h55);
      foreach (directed[i]) queue_sample(directed[i]);

      for (int p = 0; p < PHASE_COUNT; p++) begin
         wait_idle();
         write_register(abdr_pkg::CSR_DUTY_FLOOR, floors[p]);
         write_register(abdr_pkg::CSR_DUTY_CEILING, ceilings[p]);
         case (p % 4)
            0:       begin send_idle_pct = 0;  stall_pct = 0;  end
            1:       begin send_idle_pct = 85; stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  stall_pct = 85; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase
         phase_end = queued_count + WORDS_PER_PHASE;
         while (queued_count < phase_end) begin
            rounds = $urandom_range(16, 60);
            if (rounds * 4 > phase_end - queued_count) rounds = (phase_end - queued_count) / 4;
            if (rounds == 0) rounds = 1;
            queue_rounds(rounds);
         end
      end

      wait_idle();
      if (mismatch_count == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

   // Watchdog far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("tb: errors");
      $finish;
   end

endmodule
